### rtl/tdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdp_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DATA_WIDTH-1:0] quo;
    logic [DATA_WIDTH-1:0] rem;
  } div_stat_t;

endpackage

`default_nettype wire

### rtl/tdp_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tdp_div import tdp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] dividend,
  input  wire logic [DATA_WIDTH-1:0] divisor,
  output div_stat_t                  stat
);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      count;
  logic [DATA_WIDTH-1:0] dvd;
  logic [DATA_WIDTH-1:0] dsr;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;

  assign trial = {rem, dvd[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(DATA_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      quo <= '0;
      rem <= '0;
    end else if (busy) begin
      // shift in one dividend bit, subtract when it fits
      dvd <= {dvd[DATA_WIDTH-2:0], 1'b0};
      quo <= {quo[DATA_WIDTH-2:0], fits};
      rem <= fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.quo  = quo;
  assign stat.rem  = rem;

endmodule

`default_nettype wire

### rtl/trial_division_primality_test.sv
`timescale 1ns / 1ps
`default_nettype none
// 0, 1 and even numbers go from the input beat straight to the result state.
// Odd numbers try each odd trial divisor from 3 up to the first divisor or
// sqrt(number), one at a time on the one shared bit-serial divider.
// Worst case at 32 bits is about 32768 odd trial divisors.
// One item at a time: in_ready is high only while no item is in progress.
// Synchronous active-high reset clears the sequencer, divider and output valid.

module trial_division_primality_test import tdp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [DATA_WIDTH-1:0] number,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       prime_flag
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LAUNCH = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]            state;
  logic [DATA_WIDTH-1:0] num;
  logic [DATA_WIDTH-1:0] d;
  logic                  flag;
  logic                  start;
  logic                  in_beat;
  div_stat_t             stat;

  assign in_ready = (state == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign start    = (state == ST_LAUNCH);

  tdp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (num),
    .divisor  (d),
    .stat     (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_RESULT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            if (number < DATA_WIDTH'(2) || !number[0]) begin
              state <= ST_RESULT;
            end else begin
              state <= ST_LAUNCH;
            end
          end
        end
        ST_LAUNCH: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (stat.done) begin
            if (d > stat.quo || stat.rem == '0) begin
              state <= ST_RESULT;
            end else begin
              state <= ST_LAUNCH;
            end
          end
        end
        ST_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      num  <= number;
      d    <= DATA_WIDTH'(3);
      flag <= (number == DATA_WIDTH'(2));
    end else if (state == ST_WAIT && stat.done) begin
      if (d > stat.quo) begin
        flag <= 1'b1;
      end else if (stat.rem == '0) begin
        flag <= 1'b0;
      end else begin
        d <= d + DATA_WIDTH'(2);
      end
    end
    if (state == ST_RESULT && (!out_valid || out_ready)) begin
      prime_flag <= flag;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !stat.busy)
    else $error("divider started while busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == ST_WAIT)
    else $error("divider result outside wait state");

  a_odd_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT || state == ST_LAUNCH) |-> d[0] && d >= DATA_WIDTH'(3))
    else $error("trial divisor not odd or below three");

  a_even_fast: assert property (@(posedge clk) disable iff (rst)
    in_beat && !number[0] && number != DATA_WIDTH'(2) |=> state == ST_RESULT && !flag)
    else $error("even number not rejected at once");

endmodule

`default_nettype wire

### tb/trial_division_primality_test_test.sv
`timescale 1ns / 1ps

module trial_division_primality_test_test;
  import tdp_pkg::DATA_WIDTH;

  localparam int WDOG_LIMIT  = 4000000;
  localparam int SMALL_TRIAL = 64;
  localparam int MID_TRIAL   = 300;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] number;
    logic                  prime_flag;
  } prime_exp_t;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [DATA_WIDTH-1:0] number     = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic                  prime_flag;

  prime_exp_t prime_exp_q[$];
  bit         in_idle_en   = 1'b0;
  bit         out_idle_en  = 1'b0;
  int         stall_left   = 0;
  int         mismatch_cnt = 0;
  int         result_cnt   = 0;
  int         prime_cnt    = 0;
  int         max_trials   = 0;
  int         quiet_cycles = 0;

  trial_division_primality_test u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .number     (number),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .prime_flag (prime_flag)
  );

  always #5 clk = ~clk;

  function automatic bit is_prime_by_trial(input logic [DATA_WIDTH-1:0] n, output int trials);
    logic [63:0] v;
    logic [63:0] d;
    v = 64'(n);
    trials = 0;
    if (v < 64'd2) return 1'b0;
    if (v[0] == 1'b0) return v == 64'd2;
    for (d = 64'd3; d <= v / d; d += 64'd2) begin
      trials++;
      if (v % d == 64'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic push_number(input logic [DATA_WIDTH-1:0] n);
    prime_exp_t exp_item;
    int         trials;
    if (in_idle_en && $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid = 1'b1;
    number   = n;
    do @(posedge clk); while (!(in_valid && in_ready));
    exp_item.number     = n;
    exp_item.prime_flag = is_prime_by_trial(n, trials);
    if (trials > max_trials) max_trials = trials;
    prime_exp_q.push_back(exp_item);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [DATA_WIDTH-1:0] draw_number();
    logic [DATA_WIDTH-1:0] n;
    int                    trials;
    int                    lim;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        n   = $urandom() >> $urandom_range(20, 31);
        lim = SMALL_TRIAL;
      end
      5: begin
        n   = $urandom() >> $urandom_range(12, 19);
        lim = MID_TRIAL;
      end
      default: begin
        n   = $urandom();
        lim = SMALL_TRIAL;
      end
    endcase
    void'(is_prime_by_trial(n, trials));
    while (trials > lim) begin
      n = (lim == SMALL_TRIAL) ? $urandom() : ($urandom() >> $urandom_range(12, 19));
      void'(is_prime_by_trial(n, trials));
    end
    return n;
  endfunction

  task automatic test_small_values();
    push_number(0);
    push_number(1);
    push_number(2);
    push_number(3);
    push_number(4);
    push_number(5);
    push_number(7);
    push_number(9);
    push_number(15);
    push_number(25);
    push_number(49);
    push_number(121);
  endtask

  task automatic test_even_numbers();
    push_number(6);
    push_number(1000);
    push_number(32'h8000_0000);
    push_number(32'hFFFF_FFFE);
  endtask

  task automatic test_large_numbers();
    push_number(32'hFFFF_FFFF);
    push_number(65521);
    push_number(65535);
    push_number(65537);
    push_number(1000003);
    push_number(32'd4294967291);
  endtask

  task automatic test_random_numbers(input int cnt);
    repeat (cnt) push_number(draw_number());
  endtask

  task automatic test_no_idle(input int cnt);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    stall_left  = 0;
    repeat (cnt) push_number(draw_number());
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_ready  = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    prime_exp_t exp_item;
    if (!rst && out_valid && out_ready) begin
      result_cnt++;
      if (prime_flag === 1'b1) prime_cnt++;
      if (prime_exp_q.size() == 0) begin
        $error("prime_flag: beat with no expectation, actual %0b", prime_flag);
        mismatch_cnt++;
      end else begin
        exp_item = prime_exp_q.pop_front();
        if (prime_flag !== exp_item.prime_flag) begin
          $error("prime_flag for number %0d: expected %0b, actual %0b",
                 exp_item.number, exp_item.prime_flag, prime_flag);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d results pending",
                 quiet_cycles, prime_exp_q.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    test_small_values();
    test_even_numbers();
    test_large_numbers();
    test_random_numbers(75);
    test_no_idle(25);
    while (prime_exp_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("checked %0d numbers, %0d reported prime", result_cnt, prime_cnt);
    $display("deepest search: %0d odd trial divisors in one number", max_trials);
    if (mismatch_cnt == 0 && prime_exp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tdp_pkg.sv
rtl/tdp_div.sv
rtl/trial_division_primality_test.sv
tb/trial_division_primality_test_test.sv
